>>> src/round_robin_slot_scheduler_core_defines.svh
// Assertion macros used by the scheduler core.
`ifndef ROUND_ROBIN_SLOT_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_SLOT_SCHEDULER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define RRSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed one cycle later");

`endif

>>> src/rrss_pkg.sv
package rrss_pkg;

  // Field widths.
  localparam int unsigned ID_W      = 8;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned ROUND_W   = 16;
  localparam int unsigned ELAPSED_W = 32;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SLOT = 1'b1;

  // Reset values.
  localparam logic [TIME_W-1:0]  QUANTUM_RESET = 16'd10;
  localparam logic [ROUND_W-1:0] PASS_RESET    = 16'd1;

  // One task in the ring.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] remaining;
  } entry_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

endpackage

>>> src/round_robin_slot_scheduler_core.sv
// Channel   Handshake              Payload
// input     in_valid_i/in_ready_o  command_i, task_time_i, task_id_i
// output    out_valid_o/out_ready_i granted_id_o, time_left_o, finished_o,
//                                  round_number_o, elapsed_o, idle_o
// config    cfg_we_i               cfg_wdata_i (quantum)
//
// A load transaction produces no result.
// A slot transaction walks the ring from the cursor, skipping finished tasks;
// the walk reads one ring entry per cycle from the RAM. With nothing pending a
// slot visits every task in the ring and gives an idle slot; an empty ring
// answers idle without a walk; input is not ready in a walk.
// The result waits in the output register while the next transaction is taken;
// the final step stalls only while that register is still full.
// Reset is asynchronous, active low; the ring contents are not cleared.
`include "round_robin_slot_scheduler_core_defines.svh"

module round_robin_slot_scheduler_core #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rrss_pkg::TIME_W-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [rrss_pkg::TIME_W-1:0]         task_time_i,
  input  logic [rrss_pkg::ID_W-1:0]           task_id_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rrss_pkg::ID_W-1:0]           granted_id_o,
  output logic [rrss_pkg::TIME_W-1:0]         time_left_o,
  output logic                                finished_o,
  output logic [rrss_pkg::ROUND_W-1:0]        round_number_o,
  output logic [rrss_pkg::ELAPSED_W-1:0]      elapsed_o,
  output logic                                idle_o
);

  localparam int unsigned IDX_W = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_TASKS);

  typedef struct packed {
    logic [rrss_pkg::ID_W-1:0]      granted_id;
    logic [rrss_pkg::TIME_W-1:0]    time_left;
    logic                           finished;
    logic [rrss_pkg::ROUND_W-1:0]   round_number;
    logic [rrss_pkg::ELAPSED_W-1:0] elapsed;
    logic                           idle;
  } result_t;

  localparam result_t IdleResult = '{
    granted_id: '0, time_left: '0, finished: 1'b0,
    round_number: '0, elapsed: '0, idle: 1'b1
  };

  rrss_pkg::state_e state_q, state_d;
  logic [rrss_pkg::TIME_W-1:0]    quantum_q;
  logic [CNT_W-1:0]               task_count_q, task_count_d;
  logic [IDX_W-1:0]               cursor_q, cursor_d;
  logic [rrss_pkg::ROUND_W-1:0]   pass_q, pass_d;
  logic [rrss_pkg::ELAPSED_W-1:0] total_q, total_d;
  logic [IDX_W-1:0]               idx_q, idx_d;
  logic [rrss_pkg::ROUND_W-1:0]   walk_pass_q, walk_pass_d;
  logic [CNT_W-1:0]               k_q, k_d;
  result_t                        res_q, res_d;
  result_t                        out_q, out_d;
  logic                           out_valid_q, out_valid_d;

  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;
  rrss_pkg::entry_t               wr_data;
  logic [IDX_W-1:0]               rd_addr;
  rrss_pkg::entry_t               rd_data;

  logic [IDX_W-1:0]               start_idx;
  logic [IDX_W-1:0]               idx_step;
  logic [rrss_pkg::ROUND_W-1:0]   walk_pass_step;
  logic                           wrap;
  logic [CNT_W-1:0]               k_inc;
  logic [rrss_pkg::TIME_W-1:0]    used;
  logic [rrss_pkg::TIME_W-1:0]    left;
  logic [rrss_pkg::ELAPSED_W:0]   total_sum;
  logic [rrss_pkg::ELAPSED_W-1:0] total_sat;

  // Task ring storage.
  rrss_ring_ram #(
    .DEPTH (MAX_TASKS)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Walk position arithmetic: one step forward with wrap and pass bump.
  always_comb begin
    start_idx = ((task_count_q != '0) && (CNT_W'(cursor_q) < task_count_q)) ?
                cursor_q : '0;
    wrap      = (CNT_W'(idx_q) + CNT_W'(1)) >= task_count_q;
    idx_step  = wrap ? '0 : idx_q + IDX_W'(1);
    walk_pass_step = (wrap && (walk_pass_q != '1)) ?
                     walk_pass_q + rrss_pkg::ROUND_W'(1) : walk_pass_q;
    k_inc     = k_q + CNT_W'(1);
  end

  // Quantum grant and saturating elapsed total.
  always_comb begin
    used      = (rd_data.remaining < quantum_q) ? rd_data.remaining : quantum_q;
    left      = rd_data.remaining - used;
    total_sum = {1'b0, total_q} + (rrss_pkg::ELAPSED_W + 1)'(used);
    total_sat = total_sum[rrss_pkg::ELAPSED_W] ? '1 :
                total_sum[rrss_pkg::ELAPSED_W-1:0];
  end

  // Sequencer: next state, ring access and result staging.
  always_comb begin
    state_d      = state_q;
    task_count_d = task_count_q;
    cursor_d     = cursor_q;
    pass_d       = pass_q;
    total_d      = total_q;
    idx_d        = idx_q;
    walk_pass_d  = walk_pass_q;
    k_d          = k_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = rd_data;
    rd_addr      = idx_q;
    in_ready_o   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rrss_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        rd_addr    = start_idx;
        if (in_valid_i) begin
          if (command_i == rrss_pkg::CMD_LOAD) begin
            if (task_count_q < MaxCnt) begin
              wr_en        = 1'b1;
              wr_addr      = task_count_q[IDX_W-1:0];
              wr_data      = '{id: task_id_i, remaining: task_time_i};
              task_count_d = task_count_q + CNT_W'(1);
            end
          end else if (task_count_q == '0) begin
            res_d   = IdleResult;
            state_d = rrss_pkg::S_DONE;
          end else begin
            idx_d       = start_idx;
            walk_pass_d = pass_q;
            k_d         = '0;
            state_d     = rrss_pkg::S_WALK;
          end
        end
      end

      rrss_pkg::S_WALK: begin
        rd_addr = idx_step;
        if (rd_data.remaining != '0) begin
          // Serve this task and move the cursor past it.
          wr_en    = 1'b1;
          wr_addr  = idx_q;
          wr_data  = '{id: rd_data.id, remaining: left};
          total_d  = total_sat;
          cursor_d = idx_step;
          pass_d   = walk_pass_step;
          res_d    = '{
            granted_id: rd_data.id, time_left: left, finished: (left == '0),
            round_number: walk_pass_q, elapsed: total_sat, idle: 1'b0
          };
          state_d  = rrss_pkg::S_DONE;
        end else begin
          // Skip a finished task; every task in the ring finished gives an idle slot.
          idx_d       = idx_step;
          walk_pass_d = walk_pass_step;
          k_d         = k_inc;
          if (k_inc == task_count_q) begin
            res_d   = IdleResult;
            state_d = rrss_pkg::S_DONE;
          end
        end
      end

      rrss_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = rrss_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = rrss_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rrss_pkg::S_IDLE;
      quantum_q    <= rrss_pkg::QUANTUM_RESET;
      task_count_q <= '0;
      cursor_q     <= '0;
      pass_q       <= rrss_pkg::PASS_RESET;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      task_count_q <= task_count_d;
      cursor_q     <= cursor_d;
      pass_q       <= pass_d;
      total_q      <= total_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
    end
  end

  // Walk and result registers.
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    walk_pass_q <= walk_pass_d;
    k_q         <= k_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign granted_id_o   = out_q.granted_id;
  assign time_left_o    = out_q.time_left;
  assign finished_o     = out_q.finished;
  assign round_number_o = out_q.round_number;
  assign elapsed_o      = out_q.elapsed;
  assign idle_o         = out_q.idle;

  // Checks.
  `RRSS_ASSERT_NOW(a_idle_fields_zero, clk_i, rst_ni, out_valid_o && idle_o, (granted_id_o == '0) && (time_left_o == '0) && !finished_o && (round_number_o == '0) && (elapsed_o == '0))
  `RRSS_ASSERT_NOW(a_finished_matches, clk_i, rst_ni, out_valid_o && !idle_o, finished_o == (time_left_o == '0))
  `RRSS_ASSERT_NOW(a_cursor_in_ring, clk_i, rst_ni, task_count_q != '0, CNT_W'(cursor_q) < task_count_q)
  `RRSS_ASSERT_NOW(a_walk_bounded, clk_i, rst_ni, state_q == rrss_pkg::S_WALK, (k_q < task_count_q) && (CNT_W'(idx_q) < task_count_q))
  `RRSS_ASSERT_NEXT(a_slot_leaves_idle, clk_i, rst_ni, in_valid_i && in_ready_o && (command_i == rrss_pkg::CMD_SLOT), !in_ready_o)

endmodule

>>> src/rrss_ring_ram.sv
module rrss_ring_ram #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  rrss_pkg::entry_t      wr_data_i,
  input  logic [AW-1:0]         rd_addr_i,
  output rrss_pkg::entry_t      rd_data_o
);

  rrss_pkg::entry_t mem_q [DEPTH];
  rrss_pkg::entry_t rd_data_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, read every cycle.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
